// ----- rtl/tgss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgss_pkg
// Shared types, constants, microcode ROM and sine table builder for the
// sine / additive square tone generator.
// ----------------------------------------------------------------------------
package tgss_pkg;

	localparam logic [63:0] HALF_PI_Q30      = 64'd1686629713;
	localparam logic [63:0] FOUR_OVER_PI_Q32 = 64'd5468522205;

	localparam int          AMP_W   = 15;
	localparam int          HC_W    = 7;
	localparam int          Q_W     = 15;
	localparam int          COEF_W  = 17;
	localparam int          TERM_W  = 18;
	localparam int          SMP_W   = 16;
	localparam int          STEP_W  = 3;

	// Unity coefficient: sine mode reuses the harmonic path
	localparam logic [COEF_W-1:0] SINE_COEF = 17'h10000;

	// Register indexes on the write port
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_STEP  = 2'd1;
	localparam logic [1:0] REG_AMP   = 2'd2;
	localparam logic [1:0] REG_COUNT = 2'd3;

	typedef logic [STEP_W-1:0] step_t;

	// Microprogram addresses
	localparam step_t ST_IDLE  = 3'd0;
	localparam step_t ST_SEL   = 3'd1;
	localparam step_t ST_SINE  = 3'd2;
	localparam step_t ST_LOOP  = 3'd3;
	localparam step_t ST_DRAIN = 3'd4;
	localparam step_t ST_OUT   = 3'd5;
	localparam step_t ST_FIN   = 3'd6;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_MODE_SQ,
		C_MORE,
		C_BUSY,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		logic  take;
		logic  issue_sine;
		logic  issue_sq;
		logic  adv;
		logic  emit;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic mode_sq;
		logic more;
		logic busy;
		logic out_full;
	} stat_t;

	// Control store: jump to target when cond holds, else next step
	function automatic ctrl_t tgss_ucode(input step_t s);
		ctrl_t w;
		w = '{take: 1'b0, issue_sine: 1'b0, issue_sq: 1'b0, adv: 1'b0, emit: 1'b0,
			cond: C_ALWAYS, target: ST_IDLE};
		case (s)
			ST_IDLE: begin
				w.take   = 1'b1;
				w.cond   = C_NO_INPUT;
				w.target = ST_IDLE;
			end
			ST_SEL: begin
				w.cond   = C_MODE_SQ;
				w.target = ST_LOOP;
			end
			ST_SINE: begin
				w.issue_sine = 1'b1;
				w.cond       = C_ALWAYS;
				w.target     = ST_DRAIN;
			end
			ST_LOOP: begin
				w.issue_sq = 1'b1;
				w.adv      = 1'b1;
				w.cond     = C_MORE;
				w.target   = ST_LOOP;
			end
			ST_DRAIN: begin
				w.cond   = C_BUSY;
				w.target = ST_DRAIN;
			end
			ST_OUT: begin
				w.cond   = C_OUT_FULL;
				w.target = ST_OUT;
			end
			ST_FIN: begin
				w.emit   = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = ST_IDLE;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

	// Quarter-wave sine, Q1.15, Taylor series to the x^11 term in Q30
	function automatic logic [Q_W-1:0] tgss_quarter_sine(input logic [63:0] m,
			input int unsigned b);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] s;
		logic [63:0] t;
		x  = (m * HALF_PI_Q30) >> (b - 2);
		x2 = (x * x) >> 30;
		s  = x;
		t  = x;
		t  = ((t * x2) >> 30) / 64'd6;
		s  = s - t;
		t  = ((t * x2) >> 30) / 64'd20;
		s  = s + t;
		t  = ((t * x2) >> 30) / 64'd42;
		s  = s - t;
		t  = ((t * x2) >> 30) / 64'd72;
		s  = s + t;
		t  = ((t * x2) >> 30) / 64'd110;
		s  = s - t;
		s  = (s + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return s[Q_W-1:0];
	endfunction

endpackage

// ----- rtl/tgss_useq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgss_useq
// Step counter and control store; picks the next step from the jump
// condition of the current control word.
// ----------------------------------------------------------------------------
module tgss_useq import tgss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	step_t step_q;
	logic  jump;

	assign ctrl = tgss_ucode(step_q);

	always_comb begin
		case (ctrl.cond)
			C_NEVER:    jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_INPUT: jump = !stat.in_valid;
			C_MODE_SQ:  jump = stat.mode_sq;
			C_MORE:     jump = stat.more;
			C_BUSY:     jump = stat.busy;
			C_OUT_FULL: jump = stat.out_full;
			default:    jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (jump) begin
			step_q <= ctrl.target;
		end else begin
			step_q <= step_q + step_t'(1);
		end
	end

endmodule

// ----- rtl/tgss_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgss_dp
// Phase accumulator, harmonic counter, sine/coefficient lookup, four-stage
// multiply and round pipe, term accumulator and output register.
// ----------------------------------------------------------------------------
module tgss_dp import tgss_pkg::*; #(
	parameter int unsigned MAX_HARMONICS   = 64,
	parameter int unsigned SINE_TABLE_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	output stat_t             stat,
	input  logic              in_valid,
	input  logic              restart,
	input  logic              mode,
	input  logic [31:0]       phase_step,
	input  logic [AMP_W-1:0]  amp,
	input  logic [HC_W-1:0]   hcount,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SMP_W-1:0]  out_sample
);

	localparam int unsigned B   = SINE_TABLE_BITS;
	localparam int unsigned N4  = 1 << (B - 2);
	localparam int unsigned NW  = $clog2(MAX_HARMONICS) + 1;
	localparam int unsigned CW  = (NW > HC_W) ? NW : HC_W;
	localparam int unsigned CD  = 1 << (NW - 1);
	localparam int unsigned SW  = TERM_W + $clog2(MAX_HARMONICS);
	localparam logic [Q_W-1:0] QTOP = tgss_quarter_sine(64'(N4), B);
	localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
	localparam logic signed [SW-1:0] SAT_LO = -SW'(32768);

	logic [Q_W-1:0]    qtab [N4];
	logic [COEF_W-1:0] crom [CD];

	for (genvar g = 0; g < N4; g++) begin : g_qtab
		localparam logic [Q_W-1:0] QV = tgss_quarter_sine(64'(g), B);
		assign qtab[g] = QV;
	end

	for (genvar g = 0; g < CD; g++) begin : g_crom
		localparam logic [COEF_W-1:0] CV =
			COEF_W'(((FOUR_OVER_PI_Q32 / 64'(2 * g + 1)) + 64'd32768) >> 16);
		assign crom[g] = CV;
	end

	logic [31:0]         phase_acc_q;
	logic [31:0]         ph_q;
	logic [31:0]         hp_q;
	logic [NW-1:0]       n_q;
	logic signed [SW-1:0] sum_q;
	logic                out_valid_q;
	logic [SMP_W-1:0]    sample_q;

	logic [31:0]         ph_now;
	logic                load;
	logic                issue;
	logic [CW-1:0]       cnt_eff;
	logic                more;
	logic [B-1:0]        idx;
	logic [B-2:0]        m;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic [Q_W-1:0]      q_s1;
	logic                neg_s1, neg_s2, neg_s3;
	logic [COEF_W-1:0]   coef_s1, coef_s2;
	logic [29:0]         p1_s2;
	logic [46:0]         p2_s3;
	logic signed [TERM_W-1:0] term_s4;
	logic [47:0]         rnd;
	logic [TERM_W-2:0]   mag;

	assign load    = ctrl.take && in_valid;
	assign ph_now  = restart ? 32'd0 : phase_acc_q;
	assign cnt_eff = (CW'(hcount) > CW'(MAX_HARMONICS)) ? CW'(MAX_HARMONICS) : CW'(hcount);
	assign more    = CW'(n_q) < cnt_eff;
	assign issue   = ctrl.issue_sine || (ctrl.issue_sq && more);

	assign idx = hp_q[31 -: B];
	assign m   = idx[B-2] ? ((B - 1)'(N4) - {1'b0, idx[B-3:0]}) : {1'b0, idx[B-3:0]};

	assign stat = '{in_valid: in_valid, mode_sq: mode, more: more,
		busy: v_s1 || v_s2 || v_s3 || v_s4, out_full: out_valid_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= 32'd0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_acc_q <= ph_now + phase_step;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// harmonic walk: odd n only, phase advances by 2*phase per step
	always_ff @(posedge clk) begin
		if (load) begin
			ph_q <= ph_now;
			hp_q <= ph_now;
			n_q  <= NW'(1);
		end else if (ctrl.adv) begin
			hp_q <= hp_q + {ph_q[30:0], 1'b0};
			n_q  <= n_q + NW'(2);
		end
	end

	assign rnd = {1'b0, p2_s3} + 48'h0000_4000_0000;
	assign mag = rnd[47:31];

	always_ff @(posedge clk) begin
		q_s1    <= m[B-2] ? QTOP : qtab[m[B-3:0]];
		neg_s1  <= idx[B-1];
		coef_s1 <= ctrl.issue_sine ? SINE_COEF : crom[n_q[NW-1:1]];

		p1_s2   <= {15'd0, amp} * {15'd0, q_s1};
		neg_s2  <= neg_s1;
		coef_s2 <= coef_s1;

		p2_s3   <= {17'd0, p1_s2} * {30'd0, coef_s2};
		neg_s3  <= neg_s2;

		term_s4 <= neg_s3 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sum_q <= '0;
		end else if (v_s4) begin
			sum_q <= sum_q + {{(SW - TERM_W){term_s4[TERM_W-1]}}, term_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			if (sum_q > SAT_HI) begin
				sample_q <= 16'h7fff;
			end else if (sum_q < SAT_LO) begin
				sample_q <= 16'h8000;
			end else begin
				sample_q <= sum_q[SMP_W-1:0];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = sample_q;

endmodule

// ----- rtl/tone_generator_sine_square.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_generator_sine_square
// Sine / additive square-wave tone oscillator, one sample per input item.
//
// Each item on s_axis is a sample tick; bit 0 of tdata restarts the phase
// at zero before that sample. m_axis returns one signed 16-bit sample per
// item. Settings are written through cfg_we / cfg_index / cfg_data while
// the block is idle.
// A microcoded sequencer runs the item: accept, select mode, issue terms,
// drain the four-stage multiply pipe, then load the output register.
// Square mode issues one term per cycle for each odd harmonic n below
// min(harmonic_count, MAX_HARMONICS); sine mode issues a single term.
// The next item is accepted while a finished sample still waits in
// the output register. If the receiver stalls, the sample holds and the
// next item finishes its work, then waits in the output step until the
// register frees.
// Reset clears the phase, the sequencer and the output valid, and loads
// the default settings.
// ----------------------------------------------------------------------------
module tone_generator_sine_square import tgss_pkg::*; #(
	parameter int unsigned MAX_HARMONICS   = 64,
	parameter int unsigned SINE_TABLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] sample
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic              mode_q;
	logic [31:0]       phase_step_q;
	logic [AMP_W-1:0]  amp_q;
	logic [HC_W-1:0]   hcount_q;
	ctrl_t             ctrl;
	stat_t             stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			phase_step_q <= 32'd14608732;
			amp_q        <= 15'd2200;
			hcount_q     <= 7'd50;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:  mode_q       <= cfg_data[0];
				REG_STEP:  phase_step_q <= cfg_data;
				REG_AMP:   amp_q        <= cfg_data[AMP_W-1:0];
				REG_COUNT: hcount_q     <= cfg_data[HC_W-1:0];
				default:   mode_q       <= mode_q;
			endcase
		end
	end

	assign s_axis_tready = ctrl.take;

	tgss_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	tgss_dp #(
		.MAX_HARMONICS   (MAX_HARMONICS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.in_valid   (s_axis_tvalid),
		.restart    (s_axis_tdata[0]),
		.mode       (mode_q),
		.phase_step (phase_step_q),
		.amp        (amp_q),
		.hcount     (hcount_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_sample (m_axis_tdata)
	);

endmodule

// ----- rtl/tgss_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgss_chk
// Port-level checks for the tone generator, bound to the top level.
// ----------------------------------------------------------------------------
module tgss_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// stalled sample holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("sample changed or dropped under stall");

	// one item in work at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while one is in work");

	// a sample appears only from the finishing step, never from idle
	a_emit_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("sample appeared without work in progress");

endmodule

bind tone_generator_sine_square tgss_chk u_chk (.*);

// ----- sim/tb_tone_generator_sine_square.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tone_generator_sine_square
// Self-checking bench for the sine / additive square tone oscillator.
// Sample ticks are fed from a queue by a clocked driver. Each accepted tick
// runs a bit-exact software oscillator: phase accumulator, Q1.15 sine
// table, Q1.16 harmonic coefficients, 16-bit saturation. The predicted
// samples are queued and checked in order by a clocked monitor. A directed
// pass covers the default settings, the table extremes, saturation and
// the harmonic count corner values. Random passes follow, settings written
// between them; both sides stall at random, but not in the last passes.
// ----------------------------------------------------------------------------
module tb_tone_generator_sine_square;
	import tgss_pkg::*;

	localparam int TBL_BITS    = 10;
	localparam int QN          = 1 << (TBL_BITS - 2);
	localparam int MAX_HARM    = 64;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_valid       = 1'b0;
	logic [7:0]  s_data        = 8'd0;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic        m_ready       = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_index     = REG_MODE;
	logic [31:0] cfg_data      = 32'd0;

	logic        model_square = 1'b0;
	logic [31:0] model_step   = 32'd14608732;
	logic [14:0] model_amp    = 15'd2200;
	logic [6:0]  model_count  = 7'd50;
	logic [31:0] tone_phase   = 32'd0;

	logic [15:0]        quarter_rom [0:QN];
	logic               tick_queue [$];
	logic signed [15:0] expected_samples [$];

	int send_idle_pct = 26;
	int rcv_idle_pct  = 50;
	int error_count   = 0;
	int cycle_count   = 0;

	tone_generator_sine_square u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Taylor series of sin(m/QN * pi/2) in unsigned Q30, rounded to Q1.15
	function automatic logic [63:0] quarter_q15(input logic [63:0] m);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] acc;
		logic [63:0] term;
		logic [63:0] div;
		int k;
		x    = (m * HALF_PI_Q30) >> (TBL_BITS - 2);
		x2   = (x * x) >> 30;
		acc  = x;
		term = x;
		for (k = 1; k <= 5; k++) begin
			div  = 64'((2 * k) * (2 * k + 1));
			term = ((term * x2) >> 30) / div;
			if (k % 2 == 1) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		acc = (acc + 64'd16384) >> 15;
		if (acc > 64'd32767) begin
			acc = 64'd32767;
		end
		return acc;
	endfunction

	function automatic logic signed [15:0] sine_at(input logic [31:0] phase);
		logic [TBL_BITS-1:0] idx;
		logic [TBL_BITS-3:0] r;
		logic signed [15:0]  v;
		idx = phase[31 -: TBL_BITS];
		r   = idx[TBL_BITS-3:0];
		if (idx[TBL_BITS-2]) begin
			v = $signed(quarter_rom[QN - r]);
		end else begin
			v = $signed(quarter_rom[r]);
		end
		return idx[TBL_BITS-1] ? -v : v;
	endfunction

	function automatic logic signed [63:0] round_away(input logic signed [63:0] v,
			input int sh);
		logic signed [63:0] half;
		half = 64'sd1 <<< (sh - 1);
		if (v >= 0) begin
			return (v + half) >>> sh;
		end
		return -((-v + half) >>> sh);
	endfunction

	function automatic logic signed [15:0] next_tone_sample(input logic restart);
		logic signed [63:0] total;
		logic signed [63:0] amp_s;
		logic signed [63:0] coef;
		logic signed [15:0] s;
		logic [31:0]        hphase;
		int                 lim;
		int                 n;
		if (restart) begin
			tone_phase = 32'd0;
		end
		amp_s = $signed({49'd0, model_amp});
		total = 64'sd0;
		if (!model_square) begin
			s     = sine_at(tone_phase);
			total = round_away(amp_s * s, 15);
		end else begin
			lim    = (model_count > MAX_HARM) ? MAX_HARM : model_count;
			hphase = 32'd0;
			for (n = 1; n < lim; n++) begin
				hphase = hphase + tone_phase;
				if (n % 2 == 1) begin
					s     = sine_at(hphase);
					coef  = $signed(((FOUR_OVER_PI_Q32 / 64'(n)) + 64'd32768) >> 16);
					total = total + round_away(amp_s * s * coef, 31);
				end
			end
		end
		tone_phase = tone_phase + model_step;
		if (total > 64'sd32767) begin
			return 16'sh7fff;
		end
		if (total < -64'sd32768) begin
			return 16'sh8000;
		end
		return total[15:0];
	endfunction

	// Tick driver; predicts at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_valid <= 1'b0;
			s_data  <= 8'd0;
		end else begin
			if (s_valid && s_axis_tready) begin
				expected_samples.push_back(next_tone_sample(s_data[0]));
			end
			if (!s_valid || s_axis_tready) begin
				if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_valid <= 1'b1;
					s_data  <= {7'd0, tick_queue.pop_front()};
				end else begin
					s_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_ready <= 1'b0;
		end else begin
			m_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Sample monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_ready) begin
			if (expected_samples.size() == 0) begin
				$error("sample: unexpected item, actual %0d", $signed(m_axis_tdata));
				error_count++;
			end else begin
				if ($signed(m_axis_tdata) !== expected_samples[0]) begin
					$error("sample: expected %0d, actual %0d", expected_samples[0],
						$signed(m_axis_tdata));
					error_count++;
				end
				void'(expected_samples.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_tone_generator_sine_square: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_MODE:  model_square = val[0];
			REG_STEP:  model_step   = val;
			REG_AMP:   model_amp    = val[14:0];
			REG_COUNT: model_count  = val[6:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		while (tick_queue.size() != 0 || s_valid || expected_samples.size() != 0) begin
			@(negedge clk);
		end
		repeat (12) @(posedge clk);
	endtask

	initial begin
		int          i;
		int          total;
		int          n_items;
		logic [31:0] r;
		logic [31:0] val;
		for (i = 0; i <= QN; i++) begin
			quarter_rom[i] = 16'(quarter_q15(64'(i)));
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, sine
		tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b1);
		tick_queue.push_back(1'b0);
		settle();
		// reset settings, square
		write_reg(REG_MODE, 32'd1);
		end_writes();
		tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b1);
		settle();
		// full scale sine, quarter turns
		write_reg(REG_MODE, 32'd0);
		write_reg(REG_AMP, 32'd32767);
		write_reg(REG_STEP, 32'h4000_0000);
		end_writes();
		tick_queue.push_back(1'b1);
		repeat (4) tick_queue.push_back(1'b0);
		settle();
		// full scale square, all harmonics, both saturation rails
		write_reg(REG_MODE, 32'd1);
		write_reg(REG_COUNT, 32'd64);
		write_reg(REG_STEP, 32'h2000_0000);
		end_writes();
		tick_queue.push_back(1'b1);
		repeat (5) tick_queue.push_back(1'b0);
		settle();
		// no harmonic summed
		write_reg(REG_COUNT, 32'd0);
		end_writes();
		tick_queue.push_back(1'b0);
		settle();
		write_reg(REG_COUNT, 32'd1);
		end_writes();
		tick_queue.push_back(1'b0);
		settle();
		// fundamental only
		write_reg(REG_COUNT, 32'd2);
		end_writes();
		tick_queue.push_back(1'b0);
		settle();
		// count above the cap, max step
		write_reg(REG_COUNT, 32'd127);
		write_reg(REG_STEP, 32'hffff_ffff);
		end_writes();
		tick_queue.push_back(1'b0);
		tick_queue.push_back(1'b0);
		settle();
		write_reg(REG_AMP, 32'd0);
		end_writes();
		tick_queue.push_back(1'b0);
		settle();

		total = 0;
		while (total < 1150) begin
			if (total >= 767) begin
				send_idle_pct = 0;
				rcv_idle_pct  = 0;
			end else if (total >= 383) begin
				send_idle_pct = 50;
				rcv_idle_pct  = 26;
			end
			settle();
			r = ($urandom_range(1) == 0) ? $urandom() : 32'd0;
			if ($urandom_range(3) != 0) begin
				write_reg(REG_MODE, {r[31:1], 1'($urandom_range(1))});
			end
			if ($urandom_range(3) != 0) begin
				case ($urandom_range(3))
					0: val = $urandom_range(50000000);
					1: begin
						case ($urandom_range(2))
							0: val = 32'd0;
							1: val = 32'hffff_ffff;
							default: val = 32'h8000_0000;
						endcase
					end
					default: val = $urandom();
				endcase
				write_reg(REG_STEP, val);
			end
			if ($urandom_range(3) != 0) begin
				if ($urandom_range(3) == 0) begin
					val = ($urandom_range(1) == 0) ? 32'd0 : 32'd32767;
				end else begin
					val = $urandom_range(32767);
				end
				write_reg(REG_AMP, {r[31:15], val[14:0]});
			end
			if ($urandom_range(3) != 0) begin
				if ($urandom_range(5) == 0) begin
					val = $urandom_range(127, 17);
				end else begin
					val = $urandom_range(16);
				end
				write_reg(REG_COUNT, {r[31:7], val[6:0]});
			end
			end_writes();
			n_items = $urandom_range(50, 15);
			for (i = 0; i < n_items; i++) begin
				tick_queue.push_back($urandom_range(9) == 0);
			end
			total += n_items;
		end
		settle();

		if (error_count == 0) begin
			$display("tb_tone_generator_sine_square: done, clean");
		end else begin
			$display("tb_tone_generator_sine_square: done, errors");
		end
		$finish;
	end

endmodule
